@@ rtl/core/cwa_pkg.sv @@
// Shared types and constants of the cascaded window averager.
// Holds the accumulator entry layout, the divider handshake structs and the window table.
// No dependencies.
`timescale 1ns / 1ps

package cwa_pkg;

  localparam int unsigned SumW   = 23;
  localparam int unsigned CntW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LvlOW  = 4;   // width of the reported level index
  localparam int unsigned ValW   = 7;   // width of a noise level or average
  localparam int unsigned WinW   = 18;  // widest window fits in 18 bits
  localparam int unsigned CntItW = 5;   // divider iteration counter

  localparam logic [ValW-1:0]  LevelMax    = 7'd100;
  localparam logic [ValW-1:0]  ThreshReset = 7'd60;
  localparam logic [SumW-1:0]  SumMax      = 23'h7FFFFF;
  localparam logic [CntW-1:0]  CntMax      = 16'hFFFF;
  localparam logic [LvlOW-1:0] SummaryMark = 4'd12;

  // One accumulator of the cascade
  typedef struct packed {
    logic [TimeW-1:0] start;
    logic [CntW-1:0]  cnt;
    logic [SumW-1:0]  sum;
  } cwa_ent_t;

  // Divider request and response
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } cwa_div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quot;
  } cwa_div_rsp_t;

  // Window length of each cascade level in seconds
  function automatic logic [WinW-1:0] level_window(input logic [LvlOW-1:0] idx);
    logic [WinW-1:0] w;
    case (idx)
      4'd0:    w = 18'd5;
      4'd1:    w = 18'd10;
      4'd2:    w = 18'd30;
      4'd3:    w = 18'd60;
      4'd4:    w = 18'd180;
      4'd5:    w = 18'd600;
      4'd6:    w = 18'd1200;
      4'd7:    w = 18'd3600;
      4'd8:    w = 18'd10800;
      4'd9:    w = 18'd28800;
      4'd10:   w = 18'd86400;
      4'd11:   w = 18'd259200;
      default: w = 18'd259200;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/cascaded_window_averager.sv @@
// Cascaded window averager: one item walks the cascade, one level at a time.
// Each level passes S_RD, S_ADD and S_CHK; a flushed level also waits in S_DIV for the divider
// and in S_EMIT for the output; the walk ends with S_RD0, S_ADD0 (level-0 update) and S_SUM.
// Throughput: one item per walk; the next beat is taken once the summary is registered.
// Reset clears all accumulators (per-entry valid bits), the FSM and sets threshold to 60.
`timescale 1ns / 1ps

module cascaded_window_averager #(
  parameter int unsigned LEVELS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [6:0] sample_level, [38:7] time_seconds, [39] zero
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,
  // tdata: [6:0] level_average, [13:7] raw_level, [14] is_loud, [15] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // tuser: [3:0] report_level
  output logic [3:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import cwa_pkg::*;

  localparam int unsigned LvlW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ADD, S_CHK, S_DIV, S_EMIT, S_RD0, S_ADD0, S_SUM
  } state_e;

  state_e            state_q;
  logic [LvlW-1:0]   lvl_q;
  logic [TimeW-1:0]  now_q;
  logic [ValW-1:0]   latest_q;
  logic [ValW-1:0]   thresh_q;
  logic              carry_vld_q;
  logic [ValW-1:0]   carry_q;
  logic [ValW-1:0]   avg_q;
  cwa_ent_t          ent_q;

  logic              out_vld_q;
  logic [LvlOW-1:0]  out_lvl_q;
  logic [ValW-1:0]   out_avg_q;
  logic [ValW-1:0]   out_raw_q;
  logic              out_loud_q;
  logic              out_last_q;
  logic              out_ld;

  // Accumulator memory with per-entry valid bits
  cwa_ent_t          mem [LEVELS];
  cwa_ent_t          rdata_q;
  logic [LEVELS-1:0] vld_q;
  logic              rvld_q;
  logic              mem_we, mem_re;
  logic [LvlW-1:0]   mem_wa, mem_ra;
  cwa_ent_t          mem_wd;

  cwa_div_req_t      div_req;
  cwa_div_rsp_t      div_rsp;

  logic              in_acc, ofree, last_lvl, flush;
  logic [ValW-1:0]   in_lvl, add_v, div_avg;
  logic              add_en;
  logic [SumW:0]     sum_ext;
  logic [SumW-1:0]   sum_sat;
  logic [TimeW-1:0]  elapsed;
  cwa_ent_t          ent_rd, ent_add;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign ofree    = !out_vld_q || m_axis_tready_i;
  assign out_ld   = ((state_q == S_EMIT) || (state_q == S_SUM)) && ofree;
  assign last_lvl = (lvl_q == LvlW'(LEVELS - 1));
  assign in_lvl   = (s_axis_tdata_i[6:0] > LevelMax) ? LevelMax : s_axis_tdata_i[6:0];

  // Read-modify: fold in a carried average (or the sample at the end of the walk)
  always_comb begin
    ent_rd  = rvld_q ? rdata_q : '0;
    add_v   = (state_q == S_ADD0) ? latest_q : carry_q;
    add_en  = (state_q == S_ADD0) || carry_vld_q;
    sum_ext = {1'b0, ent_rd.sum} + (SumW+1)'(add_v);
    sum_sat = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
    ent_add = ent_rd;
    if (add_en && (ent_rd.cnt != CntMax)) begin
      ent_add.sum = sum_sat;
      ent_add.cnt = ent_rd.cnt + 1'b1;
    end
    if ((state_q == S_ADD) && (ent_rd.start == '0)) begin
      ent_add.start = now_q;
    end
  end

  // Window check
  assign elapsed = now_q - ent_q.start;
  assign flush   = (elapsed >= TimeW'(level_window(LvlOW'(lvl_q)))) && (ent_q.cnt != '0);

  // Memory port control
  always_comb begin
    mem_re = (state_q == S_RD) || (state_q == S_RD0);
    mem_ra = (state_q == S_RD0) ? '0 : lvl_q;
    mem_we = ((state_q == S_CHK) && !flush) || ((state_q == S_EMIT) && ofree) ||
             (state_q == S_ADD0);
    mem_wa = (state_q == S_ADD0) ? '0 : lvl_q;
    case (state_q)
      S_ADD0:  mem_wd = ent_add;
      S_EMIT:  mem_wd = '{start: now_q, cnt: '0, sum: '0};
      default: mem_wd = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rvld_q <= vld_q[mem_ra];
      end
    end
  end

  // Divider
  assign div_req.start    = (state_q == S_CHK) && flush;
  assign div_req.dividend = ent_q.sum;
  assign div_req.divisor  = ent_q.cnt;
  assign div_avg = (div_rsp.quot > SumW'(LevelMax)) ? LevelMax : div_rsp.quot[ValW-1:0];

  cwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      now_q       <= '0;
      latest_q    <= '0;
      thresh_q    <= ThreshReset;
      carry_vld_q <= 1'b0;
      carry_q     <= '0;
      avg_q       <= '0;
      ent_q       <= '0;
      out_vld_q   <= 1'b0;
      out_lvl_q   <= '0;
      out_avg_q   <= '0;
      out_raw_q   <= '0;
      out_loud_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      // a new beat is loaded or the held one drains
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            now_q       <= s_axis_tdata_i[38:7];
            latest_q    <= in_lvl;
            lvl_q       <= '0;
            carry_vld_q <= 1'b0;
            state_q     <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          ent_q   <= ent_add;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (flush) begin
            state_q <= S_DIV;
          end else begin
            carry_vld_q <= 1'b0;
            if (last_lvl) begin
              state_q <= S_RD0;
            end else begin
              lvl_q   <= lvl_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            avg_q   <= div_avg;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ofree) begin
            out_lvl_q   <= LvlOW'(lvl_q);
            out_avg_q   <= avg_q;
            out_raw_q   <= latest_q;
            out_loud_q  <= (latest_q > thresh_q);
            out_last_q  <= 1'b0;
            carry_vld_q <= 1'b1;
            carry_q     <= avg_q;
            if (last_lvl) begin
              state_q <= S_RD0;
            end else begin
              lvl_q   <= lvl_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_RD0: begin
          state_q <= S_ADD0;
        end
        S_ADD0: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (ofree) begin
            out_lvl_q  <= SummaryMark;
            out_avg_q  <= '0;
            out_raw_q  <= latest_q;
            out_loud_q <= (latest_q > thresh_q);
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_loud_q, out_raw_q, out_avg_q};
  assign m_axis_tuser_o  = out_lvl_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ rtl/core/cwa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the level averages.
// Depends on cwa_pkg for the request and response structs.
`timescale 1ns / 1ps

module cwa_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cwa_pkg::cwa_div_req_t req_i,
  output cwa_pkg::cwa_div_rsp_t rsp_o
);
  import cwa_pkg::*;

  logic              busy_q, done_q;
  logic [CntItW-1:0] it_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW-1:0]   dsor_q;
  logic [SumW-1:0]   dq_q;     // dividend bits shift out, quotient bits shift in

  logic [CntW:0]     trial;
  logic              qbit;
  logic [CntW-1:0]   rem_d;

  // One restoring step
  always_comb begin
    trial = {rem_q, dq_q[SumW-1]};
    qbit  = (trial >= {1'b0, dsor_q});
    rem_d = qbit ? CntW'(trial - {1'b0, dsor_q}) : trial[CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= CntItW'(SumW - 1);
      end else if (busy_q) begin
        it_q <= it_q - 1'b1;
        if (it_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      dsor_q <= req_i.divisor;
      dq_q   <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[SumW-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;

endmodule
